// File: sv/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

    localparam int unsigned SIDE = 5;
    localparam int unsigned CELLS = SIDE * SIDE;

    localparam logic [7:0] PAD_CHAR   = 8'h78;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // register indexes, byte address = 8 * index
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_SQ_0  = 3'd1;
    localparam logic [2:0] REG_SQ_8  = 3'd2;
    localparam logic [2:0] REG_SQ_16 = 3'd3;
    localparam logic [2:0] REG_SQ_24 = 3'd4;

    typedef logic [CELLS-1:0][7:0] square_t;

    typedef struct packed {
        logic       found;
        logic [2:0] row;
        logic [2:0] col;
    } loc_t;

    typedef struct packed {
        logic [7:0] c0;
        logic       a0;
        logic [7:0] c1;
        logic       a1;
    } digraph_t;

    // last row holding the letter, leftmost column within that row
    function automatic loc_t locate(square_t sq, logic [7:0] ch);
        loc_t res;
        res = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int k = SIDE - 1; k >= 0; k--) begin
                if (sq[r * SIDE + k] == ch) begin
                    res.found = 1'b1;
                    res.row   = 3'(r);
                    res.col   = 3'(k);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [2:0] shift_pos(logic [2:0] p, logic enc);
        logic [2:0] res;
        if (enc) begin
            res = (p == 3'(SIDE - 1)) ? 3'd0 : 3'(p + 3'd1);
        end
        else begin
            res = (p == 3'd0) ? 3'(SIDE - 1) : 3'(p - 3'd1);
        end
        return res;
    endfunction

    function automatic logic [4:0] cell_index(logic [2:0] r, logic [2:0] c);
        logic [4:0] rr;
        rr = {2'b00, r};
        return 5'(rr << 2) + rr + {2'b00, c};
    endfunction

    function automatic digraph_t cipher_pair(square_t sq, logic enc,
                                             logic [7:0] a, logic [7:0] b);
        digraph_t   res;
        loc_t       la;
        loc_t       lb;
        logic [2:0] ra;
        logic [2:0] ca;
        logic [2:0] rb;
        logic [2:0] cb;
        la = locate(sq, a);
        lb = locate(sq, b);
        ra = la.row;
        ca = la.col;
        rb = lb.row;
        cb = lb.col;
        if (!la.found || !lb.found) begin
            res.c0 = a;
            res.a0 = !la.found;
            res.c1 = b;
            res.a1 = !lb.found;
        end
        else begin
            if (la.row == lb.row) begin
                ca = shift_pos(la.col, enc);
                cb = shift_pos(lb.col, enc);
            end
            else if (la.col == lb.col) begin
                ra = shift_pos(la.row, enc);
                rb = shift_pos(lb.row, enc);
            end
            else begin
                ca = lb.col;
                cb = la.col;
            end
            res.c0 = sq[cell_index(ra, ca)];
            res.a0 = 1'b0;
            res.c1 = sq[cell_index(rb, cb)];
            res.a1 = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/playfair_digraph_cipher_core.sv
`default_nettype none

// Playfair digraph cipher over a 5x5 key square loaded through the APB port
// (mode at 0x00, letters 0-7 at 0x08, 8-15 at 0x10, 16-23 at 0x18, letter 24
// at 0x20, byte k of a word is letter base+k). Characters stream in on the
// slave side with tlast marking the end of a message; spaces are skipped,
// raw pairs are split by 'x' when doubled and a lone letter at message end
// is padded with 'x'. Each item passes from its input register through
// combinational square lookup into a four-entry result buffer; a new item
// is taken only once the buffer is empty or its last letter is leaving, so
// the rate is set by the master port draining one letter per cycle while
// m_tready is high. tuser flags a letter absent from the square
// and tlast marks the final letter caused by an input item.
module playfair_digraph_cipher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    // character input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_in
    input  wire logic        s_tlast,   // message_end
    // cipher letters
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // char_out
    output logic             m_tuser,   // not_in_square
    output logic             m_tlast    // run_last
);
    import pfc_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       absent;
    } res_t;

    // configuration
    logic    mode_reg;
    square_t sq_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_end_reg;

    // pairing state
    logic       raw_odd_reg;
    logic [7:0] raw_first_reg;
    logic       prep_held_reg;
    logic [7:0] prep_char_reg;

    // result buffer
    res_t [3:0] buf_reg;
    logic [2:0] cnt_reg;

    logic       cfg_write;
    logic       s_fire;
    logic       m_fire;
    logic       buf_free;
    logic       process;

    logic [3:0][7:0] seq;
    logic [2:0]      seq_n;
    logic            non_space;
    digraph_t        dg0;
    digraph_t        dg1;

    logic       raw_odd_next;
    logic [7:0] raw_first_next;
    logic       prep_held_next;
    logic [7:0] prep_char_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[5:3])
            REG_MODE:  prdata = {63'd0, mode_reg};
            REG_SQ_0:  prdata = sq_reg[7:0];
            REG_SQ_8:  prdata = sq_reg[15:8];
            REG_SQ_16: prdata = sq_reg[23:16];
            REG_SQ_24: prdata = {56'd0, sq_reg[24]};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
            sq_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[5:3])
                REG_MODE:  mode_reg       <= pwdata[0];
                REG_SQ_0:  sq_reg[7:0]    <= pwdata;
                REG_SQ_8:  sq_reg[15:8]   <= pwdata;
                REG_SQ_16: sq_reg[23:16]  <= pwdata;
                REG_SQ_24: sq_reg[24]     <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    // handshakes
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_fire   = m_tvalid && m_tready;
    assign buf_free = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);
    assign process  = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || process;
    assign s_fire   = s_tvalid && s_tready;

    assign m_tdata = buf_reg[0].ch;
    assign m_tuser = buf_reg[0].absent;
    assign m_tlast = (cnt_reg == 3'd1);

    // prepared letter sequence: held letter first, then this item's letters
    assign non_space = (in_char_reg != SPACE_CHAR);

    always_comb
    begin
        seq   = '0;
        seq_n = 3'd0;
        if (prep_held_reg)
        begin
            seq[0] = prep_char_reg;
            seq_n  = 3'd1;
        end
        if (non_space && raw_odd_reg)
        begin
            seq[seq_n[1:0]] = raw_first_reg;
            seq_n           = 3'(seq_n + 3'd1);
            if (raw_first_reg == in_char_reg)
            begin
                seq[seq_n[1:0]] = PAD_CHAR;
                seq_n           = 3'(seq_n + 3'd1);
            end
            seq[seq_n[1:0]] = in_char_reg;
            seq_n           = 3'(seq_n + 3'd1);
        end
        else if (in_end_reg && (non_space || raw_odd_reg))
        begin
            // lone raw letter flushed at message end
            seq[seq_n[1:0]] = non_space ? in_char_reg : raw_first_reg;
            seq_n           = 3'(seq_n + 3'd1);
        end
        if (in_end_reg && seq_n[0])
        begin
            seq[seq_n[1:0]] = PAD_CHAR;
            seq_n           = 3'(seq_n + 3'd1);
        end
    end

    assign dg0 = cipher_pair(sq_reg, mode_reg, seq[0], seq[1]);
    assign dg1 = cipher_pair(sq_reg, mode_reg, seq[2], seq[3]);

    always_comb
    begin
        if (in_end_reg)
        begin
            raw_odd_next   = 1'b0;
            raw_first_next = 8'd0;
            prep_held_next = 1'b0;
            prep_char_next = 8'd0;
        end
        else
        begin
            raw_odd_next   = non_space ? !raw_odd_reg : raw_odd_reg;
            raw_first_next = (non_space && !raw_odd_reg) ? in_char_reg : raw_first_reg;
            prep_held_next = seq_n[0];
            prep_char_next = seq_n[0] ? seq[{seq_n[1], 1'b0}] : prep_char_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            raw_odd_reg   <= 1'b0;
            raw_first_reg <= 8'd0;
            prep_held_reg <= 1'b0;
            prep_char_reg <= 8'd0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end

            if (process)
            begin
                raw_odd_reg   <= raw_odd_next;
                raw_first_reg <= raw_first_next;
                prep_held_reg <= prep_held_next;
                prep_char_reg <= prep_char_next;
                cnt_reg       <= {seq_n[2:1], 1'b0};
            end
            else if (m_fire)
            begin
                cnt_reg <= 3'(cnt_reg - 3'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (process)
        begin
            buf_reg[0] <= '{ch: dg0.c0, absent: dg0.a0};
            buf_reg[1] <= '{ch: dg0.c1, absent: dg0.a1};
            buf_reg[2] <= '{ch: dg1.c0, absent: dg1.a0};
            buf_reg[3] <= '{ch: dg1.c1, absent: dg1.a1};
        end
        else if (m_fire)
        begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
            buf_reg[2] <= buf_reg[3];
        end
    end

    // assertions
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result count out of range");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && !buf_free)
        else $error("input stalled without a pending item");

    a_load_even: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> !cnt_reg[0])
        else $error("odd number of letters loaded");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        process && in_end_reg |=> !raw_odd_reg && !prep_held_reg)
        else $error("pairing state not cleared at message end");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        process |-> cnt_reg == 3'd0 || (cnt_reg == 3'd1 && m_fire))
        else $error("result buffer overwritten");

endmodule

`default_nettype wire
